[src/pcb_pkg.sv]
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared types and constants of the PIF command block processor.
// ----------------------------------------------------------------------------
package pcb_pkg;

    localparam int RAM_BYTES = 64;
    localparam int AW        = $clog2(RAM_BYTES);
    // Walk position: wide enough for the largest frame advance past the RAM end
    localparam int PW        = 8;

    localparam logic [AW-1:0] CTRL_ADDR = AW'(RAM_BYTES - 1);
    localparam logic [PW-1:0] RAM_END   = PW'(RAM_BYTES);
    localparam logic [PW-1:0] CTRL_POS  = PW'(RAM_BYTES - 1);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PROC  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Frame header codes (low six bits of the transmit length byte)
    localparam logic [5:0] TX_SKIP    = 6'h00;
    localparam logic [5:0] TX_CH_SKIP = 6'h3D;
    localparam logic [5:0] TX_END     = 6'h3E;
    localparam logic [5:0] TX_PAD     = 6'h3F;

    localparam logic [7:0] RX_SET     = 8'h80;
    localparam logic [7:0] RX_END     = 8'hFE;

    // Commands
    localparam logic [7:0] CMD_RESET     = 8'hFF;
    localparam logic [7:0] CMD_STATUS    = 8'h00;
    localparam logic [7:0] CMD_BUTTONS   = 8'h01;
    localparam logic [7:0] CMD_ACC_READ  = 8'h02;
    localparam logic [7:0] CMD_ACC_WRITE = 8'h03;

    // Status response bytes
    localparam logic [7:0] STAT_B0 = 8'h05;
    localparam logic [7:0] STAT_B1 = 8'h00;
    localparam logic [7:0] STAT_B2 = 8'h01;

    // Control byte
    localparam logic [7:0] CTRL_CLR_MASK = 8'hF7;
    localparam logic [7:0] CTRL_RESET_BITS = 8'h30;
    localparam logic [7:0] CTRL_RESET_VAL  = 8'h80;
    localparam logic [7:0] CTRL_TOUCH_BITS = 8'h38;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic [AW-1:0] raddr;
    } t_ram_req;

endpackage

[src/pcb_if.sv]
// ----------------------------------------------------------------------------
// pcb_in_if / pcb_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pcb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  addr;
    logic [7:0]  wdata;
    logic [31:0] buttons;

    modport source (output valid, op, addr, wdata, buttons, input ready);
    modport sink   (input valid, op, addr, wdata, buttons, output ready);
endinterface

interface pcb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       status;
    logic [5:0] channel_count;

    modport source (output valid, rdata, status, channel_count, input ready);
    modport sink   (input valid, rdata, status, channel_count, output ready);
endinterface

[src/pcb_cmd_ram.sv]
// ----------------------------------------------------------------------------
// pcb_cmd_ram
// Command RAM: one write and one read port, registered read data. Per-entry
// valid bits make entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module pcb_cmd_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcb_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);

    logic [7:0]                  mem [pcb_pkg::RAM_BYTES];
    logic [pcb_pkg::RAM_BYTES-1:0] r_valid;
    logic [7:0]                  r_rdata;
    logic                        r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_req.raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'h00;

endmodule

[src/pif_command_block_processor.sv]
// ----------------------------------------------------------------------------
// pif_command_block_processor
// Byte-addressed joybus command RAM with an in-place command block walker.
// ----------------------------------------------------------------------------
// Process: with control bit 0 clear only the control byte is finished; else the
//   walker first steps over header bytes, command frames and response bytes.
// Throughput: one transaction at a time; the walk is set by the single
//   read port of the command RAM.
// Reset: synchronous, active low; RAM entries read as zero until written,
//   channel counter cleared, no clearing pass.
module pif_command_block_processor (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pcb_in_if.sink           i_in,
    pcb_out_if.source        o_out
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_RDATA = 11'b000_0000_0010,
        S_CTL   = 11'b000_0000_0100,
        S_TREQ  = 11'b000_0000_1000,
        S_T     = 11'b000_0001_0000,
        S_R     = 11'b000_0010_0000,
        S_CMD   = 11'b000_0100_0000,
        S_WR    = 11'b000_1000_0000,
        S_FINRD = 11'b001_0000_0000,
        S_FIN   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [pcb_pkg::PW-1:0]  r_pos;
    logic [pcb_pkg::PW-1:0]  r_base;
    logic [5:0]              r_t;
    logic [5:0]              r_rlen;
    logic                    r_oob;
    logic [1:0]              r_k;
    logic [1:0]              r_last;
    logic                    r_btn;
    logic [7:0]              r_control;
    logic [31:0]             r_buttons;
    logic [5:0]              r_ctr;
    logic                    r_err;
    logic [7:0]              r_rhold;
    logic                    r_out_valid;
    logic [7:0]              r_out_rdata;
    logic                    r_out_status;
    logic [5:0]              r_out_ctr;

    pcb_pkg::t_ram_req       ram_req;
    logic [7:0]              ram_rdata;

    logic                    out_free;
    logic                    in_accept;
    logic                    out_load_now;
    logic                    out_load_done;
    logic [5:0]              hdr_t;
    logic [7:0]              rx_byte;
    logic [7:0]              cmd_byte;
    logic [pcb_pkg::PW-1:0]  pos_p1;
    logic [pcb_pkg::PW-1:0]  pos_p2;
    logic [pcb_pkg::PW-1:0]  frame_base;
    logic [pcb_pkg::PW-1:0]  wr_pos;
    logic [7:0]              wr_byte;
    logic [7:0]              fin_byte;

    pcb_cmd_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign out_free      = !r_out_valid || o_out.ready;
    assign i_in.ready    = (r_state == S_IDLE) && out_free;
    assign in_accept     = i_in.valid && i_in.ready;
    assign out_load_now  = in_accept && (i_in.op == pcb_pkg::OP_WRITE
                                      || i_in.op == pcb_pkg::OP_NONE);
    assign out_load_done = (r_state == S_DONE) && out_free;

    assign hdr_t      = ram_rdata[5:0];
    assign rx_byte    = ram_rdata | pcb_pkg::RX_SET;
    assign cmd_byte   = r_oob ? 8'h00 : ram_rdata;
    assign pos_p1     = r_pos + pcb_pkg::PW'(1);
    assign pos_p2     = r_pos + pcb_pkg::PW'(2);
    assign frame_base = pos_p2 + {2'b00, r_t};
    assign wr_pos     = r_base + {6'b00_0000, r_k};

    always_comb begin
        if (r_btn) begin
            unique case (r_k)
                2'd0:    wr_byte = r_buttons[31:24];
                2'd1:    wr_byte = r_buttons[23:16];
                2'd2:    wr_byte = r_buttons[15:8];
                default: wr_byte = r_buttons[7:0];
            endcase
        end else begin
            unique case (r_k)
                2'd0:    wr_byte = pcb_pkg::STAT_B0;
                2'd1:    wr_byte = pcb_pkg::STAT_B1;
                default: wr_byte = pcb_pkg::STAT_B2;
            endcase
        end
    end

    // Bit 3 clear acts on the current byte; the reset test uses the sampled one
    always_comb begin
        fin_byte = ram_rdata;
        if (r_control[3]) begin
            fin_byte = fin_byte & pcb_pkg::CTRL_CLR_MASK;
        end
        if ((r_control & pcb_pkg::CTRL_RESET_BITS) != 8'h00) begin
            fin_byte = pcb_pkg::CTRL_RESET_VAL;
        end
    end

    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.waddr = pcb_pkg::CTRL_ADDR;
        ram_req.wdata = 8'h00;
        ram_req.raddr = pcb_pkg::CTRL_ADDR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.op == pcb_pkg::OP_READ) begin
                    ram_req.raddr = i_in.addr;
                end
                if (in_accept && i_in.op == pcb_pkg::OP_WRITE) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = i_in.addr;
                    ram_req.wdata = i_in.wdata;
                end
            end
            S_TREQ:  ram_req.raddr = r_pos[pcb_pkg::AW-1:0];
            S_T:     ram_req.raddr = pos_p1[pcb_pkg::AW-1:0];
            S_R:     ram_req.raddr = pos_p2[pcb_pkg::AW-1:0];
            S_WR: begin
                // drop response bytes past the RAM end
                ram_req.we    = wr_pos < pcb_pkg::RAM_END;
                ram_req.waddr = wr_pos[pcb_pkg::AW-1:0];
                ram_req.wdata = wr_byte;
            end
            S_FIN: begin
                ram_req.we    = (r_control & pcb_pkg::CTRL_TOUCH_BITS) != 8'h00;
                ram_req.wdata = fin_byte;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.op == pcb_pkg::OP_READ) begin
                        n_state = S_RDATA;
                    end else if (i_in.op == pcb_pkg::OP_PROC) begin
                        n_state = S_CTL;
                    end
                end
            end
            S_RDATA: n_state = S_DONE;
            S_CTL:   n_state = ram_rdata[0] ? S_TREQ : S_FINRD;
            S_TREQ:  n_state = (r_pos < pcb_pkg::CTRL_POS) ? S_T : S_FINRD;
            S_T: begin
                priority if (hdr_t == pcb_pkg::TX_SKIP || hdr_t == pcb_pkg::TX_CH_SKIP
                             || hdr_t == pcb_pkg::TX_PAD) begin
                    n_state = S_TREQ;
                end else if (hdr_t == pcb_pkg::TX_END) begin
                    n_state = S_FINRD;
                end else begin
                    n_state = S_R;
                end
            end
            S_R: n_state = (rx_byte == pcb_pkg::RX_END) ? S_FINRD : S_CMD;
            S_CMD: begin
                priority if (cmd_byte == pcb_pkg::CMD_RESET || cmd_byte == pcb_pkg::CMD_STATUS
                             || cmd_byte == pcb_pkg::CMD_BUTTONS) begin
                    n_state = S_WR;
                end else if (cmd_byte == pcb_pkg::CMD_ACC_READ
                             || cmd_byte == pcb_pkg::CMD_ACC_WRITE) begin
                    n_state = S_TREQ;
                end else begin
                    n_state = S_FINRD;
                end
            end
            S_WR:    n_state = (r_k == r_last) ? S_TREQ : S_WR;
            S_FINRD: n_state = S_FIN;
            S_FIN:   n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctr       <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load_now || out_load_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CTL: begin
                    if (ram_rdata[0]) begin
                        r_ctr <= 6'd0;
                    end
                end
                S_T: begin
                    if (hdr_t == pcb_pkg::TX_SKIP || hdr_t == pcb_pkg::TX_CH_SKIP) begin
                        r_ctr <= r_ctr + 6'd1;
                    end
                end
                S_CMD: begin
                    if (cmd_byte == pcb_pkg::CMD_RESET) begin
                        r_ctr <= r_ctr + 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Walk datapath and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_buttons <= i_in.buttons;
            r_err     <= 1'b0;
            r_rhold   <= 8'h00;
        end
        unique case (r_state)
            S_RDATA: r_rhold <= ram_rdata;
            S_CTL: begin
                r_control <= ram_rdata;
                r_pos     <= '0;
            end
            S_T: begin
                r_t <= hdr_t;
                if (hdr_t == pcb_pkg::TX_SKIP || hdr_t == pcb_pkg::TX_CH_SKIP
                    || hdr_t == pcb_pkg::TX_PAD) begin
                    r_pos <= pos_p1;
                end
            end
            S_R: begin
                r_rlen <= rx_byte[5:0];
                r_oob  <= pos_p2 >= pcb_pkg::RAM_END;
            end
            S_CMD: begin
                r_base <= frame_base;
                r_pos  <= frame_base + {2'b00, r_rlen};
                r_k    <= 2'd0;
                r_btn  <= cmd_byte == pcb_pkg::CMD_BUTTONS;
                r_last <= (cmd_byte == pcb_pkg::CMD_BUTTONS) ? 2'd3 : 2'd2;
                if (cmd_byte != pcb_pkg::CMD_RESET && cmd_byte != pcb_pkg::CMD_STATUS
                    && cmd_byte != pcb_pkg::CMD_BUTTONS
                    && cmd_byte != pcb_pkg::CMD_ACC_READ
                    && cmd_byte != pcb_pkg::CMD_ACC_WRITE) begin
                    r_err <= 1'b1;
                end
            end
            S_WR: r_k <= r_k + 2'd1;
            default: ;
        endcase
        if (out_load_now) begin
            r_out_rdata  <= 8'h00;
            r_out_status <= 1'b0;
            r_out_ctr    <= r_ctr;
        end else if (out_load_done) begin
            r_out_rdata  <= r_rhold;
            r_out_status <= r_err;
            r_out_ctr    <= r_ctr;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.rdata         = r_out_rdata;
    assign o_out.status        = r_out_status;
    assign o_out.channel_count = r_out_ctr;

endmodule
